### design/ofm_pkg.sv
`default_nettype none

package ofm_pkg;

    // Bit positions of the six fault flags.
    localparam int FLAG_OVP = 0;
    localparam int FLAG_OVW = 1;
    localparam int FLAG_UVP = 2;
    localparam int FLAG_UVW = 3;
    localparam int FLAG_OCP = 4;
    localparam int FLAG_OCW = 5;
    localparam int NUM_FLAGS = 6;

    // Pin debounce: the pin must be seen high for more than this many ticks.
    localparam logic [1:0] PIN_DELAY = 2'd1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_OVP_VOLTAGE_LIMIT  = 3'd0,
        REG_OVW_VOLTAGE_LIMIT  = 3'd1,
        REG_UVP_VOLTAGE_LIMIT  = 3'd2,
        REG_OCP_CURRENT_LIMITS = 3'd3,
        REG_OCW_CURRENT_LIMITS = 3'd4,
        REG_VOLTAGE_DELAYS     = 3'd5,
        REG_FAULT_DELAYS       = 3'd6
    } t_reg_index;

    typedef logic [NUM_FLAGS-1:0] t_flags;

    typedef struct packed {
        logic [15:0] ovp_voltage_limit;
        logic [15:0] ovw_voltage_limit;
        logic [15:0] uvp_voltage_limit;
        logic [63:0] ocp_current_limits;
        logic [31:0] ocw_current_limits;
        logic [23:0] voltage_delays;
        logic [47:0] fault_delays;
    } t_cfg;

    typedef struct packed {
        logic        converter_enabled;
        logic        ovp_pin_high;
        logic [15:0] output_voltage;
        logic [15:0] output_current;
        logic        current_limit_active;
        logic        high_line_input;
        logic        ct_overcurrent;
        logic        clear_ov_latch;
        logic        clear_uv_latch;
        logic        clear_oc_latch;
    } t_item;

    typedef struct packed {
        logic [1:0]  pin_count;
        logic [7:0]  ovp_count;
        logic [15:0] ovw_count;
        logic [15:0] uvp_count;
        logic [15:0] ocp_count;
        logic [15:0] ocw_count;
        t_flags      flags;
    } t_state;

endpackage

`default_nettype wire

### design/ofm_step.sv
`default_nettype none

// Next-state logic of the monitor for one tick.
module ofm_step
    import ofm_pkg::*;
(
    input  wire t_state i_state,
    input  wire t_cfg   i_cfg,
    input  wire t_item  i_item,
    output t_state      o_state
);

    // 16-bit counter increment that holds at its top value.
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    logic [7:0]  ovp_dly;
    logic [15:0] ovw_dly;
    logic [15:0] uvp_dly;
    logic [15:0] ocp_dly;
    logic [15:0] ocw_dly;
    logic [15:0] ocp_lim;
    logic [15:0] mode_lim;
    logic [15:0] ocw_lim;
    logic        under;
    logic [15:0] ocp_inc;

    assign ovp_dly  = i_cfg.voltage_delays[7:0];
    assign ovw_dly  = i_cfg.voltage_delays[23:8];
    assign uvp_dly  = i_cfg.fault_delays[15:0];
    assign ocp_dly  = i_cfg.fault_delays[31:16];
    assign ocw_dly  = i_cfg.fault_delays[47:32];
    assign ocp_lim  = i_item.high_line_input ? i_cfg.ocp_current_limits[15:0]
                                             : i_cfg.ocp_current_limits[31:16];
    assign mode_lim = i_item.high_line_input ? i_cfg.ocp_current_limits[47:32]
                                             : i_cfg.ocp_current_limits[63:48];
    assign ocw_lim  = i_item.high_line_input ? i_cfg.ocw_current_limits[31:16]
                                             : i_cfg.ocw_current_limits[15:0];
    assign under    = i_item.output_voltage < i_cfg.uvp_voltage_limit;
    assign ocp_inc  = sat_inc(i_state.ocp_count);

    always_comb begin
        t_state n;
        t_flags f;
        n = i_state;
        f = i_state.flags;

        if (i_item.converter_enabled) begin
            // Hardware over-voltage pin debounce.
            if (i_item.ovp_pin_high) begin
                if (i_state.pin_count > PIN_DELAY) begin
                    f[FLAG_OVP] = 1'b1;
                    f[FLAG_OVW] = 1'b1;
                    n.pin_count = '0;
                end else begin
                    n.pin_count = i_state.pin_count + 2'd1;
                end
            end

            // Over-voltage and over-voltage warning.
            if (i_item.output_voltage > i_cfg.ovp_voltage_limit) begin
                if (i_state.ovp_count >= ovp_dly) begin
                    f[FLAG_OVP] = 1'b1;
                    f[FLAG_OVW] = 1'b1;
                end else begin
                    n.ovp_count = i_state.ovp_count + 8'd1;
                end
            end else begin
                if (i_state.ovp_count != '0) begin
                    n.ovp_count = i_state.ovp_count - 8'd1;
                end
                if (i_item.output_voltage > i_cfg.ovw_voltage_limit) begin
                    if (i_state.ovw_count > ovw_dly) begin
                        f[FLAG_OVW] = 1'b1;
                    end else begin
                        n.ovw_count = sat_inc(i_state.ovw_count);
                    end
                end else begin
                    n.ovw_count = '0;
                    f[FLAG_OVW] = 1'b0;
                end
            end

            // Under-voltage, masked while the converter is in current limit.
            if (under && !i_item.current_limit_active) begin
                if (i_state.uvp_count > uvp_dly) begin
                    f[FLAG_UVP] = 1'b1;
                    f[FLAG_UVW] = 1'b1;
                    n.uvp_count = '0;
                end else begin
                    n.uvp_count = sat_inc(i_state.uvp_count);
                end
            end else begin
                n.uvp_count = '0;
                f[FLAG_UVW] = 1'b0;
            end

            // Over-current, including the current-mode trip under low voltage.
            if ((i_item.output_current > ocp_lim) ||
                (under && (i_item.output_current > mode_lim))) begin
                if (ocp_inc > ocp_dly) begin
                    n.ocp_count = '0;
                    f[FLAG_OCP] = 1'b1;
                    f[FLAG_OCW] = 1'b1;
                end else begin
                    n.ocp_count = ocp_inc;
                end
            end else if (i_item.output_current > ocw_lim) begin
                if (i_state.ocp_count != '0) begin
                    n.ocp_count = i_state.ocp_count - 16'd1;
                end
                if (i_state.ocw_count > ocw_dly) begin
                    f[FLAG_OCW] = 1'b1;
                end else begin
                    n.ocw_count = sat_inc(i_state.ocw_count);
                end
            end else begin
                n.ocp_count = '0;
                n.ocw_count = '0;
                f[FLAG_OCW] = 1'b0;
            end

            if (i_item.ct_overcurrent) begin
                f[FLAG_OCP] = 1'b1;
                f[FLAG_OCW] = 1'b1;
            end
        end else begin
            n.pin_count = '0;
            n.ovp_count = '0;
            n.ovw_count = '0;
            n.uvp_count = '0;
            n.ocp_count = '0;
            n.ocw_count = '0;
        end

        // Latch clears act on every tick, enabled or not.
        if (i_item.clear_ov_latch) f[FLAG_OVP] = 1'b0;
        if (i_item.clear_uv_latch) f[FLAG_UVP] = 1'b0;
        if (i_item.clear_oc_latch) f[FLAG_OCP] = 1'b0;

        n.flags = f;
        o_state = n;
    end

endmodule

`default_nettype wire

### design/output_fault_monitor_unit.sv
// Output fault monitor.
//
// Each monitor tick arrives as one transfer on the input channel (i_in_valid,
// o_in_stall) carrying the enable, the over-voltage pin, the voltage and
// current samples, the line and limit flags and the three latch clears. For
// every tick the block returns one transfer on the output channel
// (o_out_valid, i_out_stall) with the six fault flags as they stand after it.
// Thresholds and delays are written through the configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data); o_cfg_ready is always
// high, and an index past the last register is accepted and ignored.
// The tick is captured in an input register at the edge of its transfer,
// evaluated combinationally against the stored state, and its flags captured
// in the output register at the next edge unless the output register is held
// by a stall. One tick per cycle is sustained while the receiver does not
// stall; the counters update against the stored state as each tick advances.
// While the receiver stalls, the result holds in the output register and one
// more tick can still be taken into the input register; after that o_in_stall
// rises until the output side moves.
// A synchronous reset (i_rst_n low) clears all counters, the monitor flags,
// configuration registers and both valid bits; the output flag register is not reset.

`default_nettype none

module output_fault_monitor_unit
    import ofm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,

    // Tick input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_converter_enabled,
    input  wire logic        i_ovp_pin_high,
    input  wire logic [15:0] i_output_voltage,
    input  wire logic [15:0] i_output_current,
    input  wire logic        i_current_limit_active,
    input  wire logic        i_high_line_input,
    input  wire logic        i_ct_overcurrent,
    input  wire logic        i_clear_ov_latch,
    input  wire logic        i_clear_uv_latch,
    input  wire logic        i_clear_oc_latch,

    // Flag output channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_ovp_flag,
    output logic             o_ovw_flag,
    output logic             o_uvp_flag,
    output logic             o_uvw_flag,
    output logic             o_ocp_flag,
    output logic             o_ocw_flag
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_item  r_item;
    logic   r_in_valid;
    logic   r_out_valid;
    t_flags r_out_flags;

    logic   out_free;
    logic   advance;
    logic   in_take;

    // The output register can load when it is empty or being read this cycle.
    // The held tick then moves forward and the monitor state updates with it,
    // so the next tick in the input register always sees current counters.
    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OVP_VOLTAGE_LIMIT:  r_cfg.ovp_voltage_limit  <= i_cfg_data[15:0];
                REG_OVW_VOLTAGE_LIMIT:  r_cfg.ovw_voltage_limit  <= i_cfg_data[15:0];
                REG_UVP_VOLTAGE_LIMIT:  r_cfg.uvp_voltage_limit  <= i_cfg_data[15:0];
                REG_OCP_CURRENT_LIMITS: r_cfg.ocp_current_limits <= i_cfg_data;
                REG_OCW_CURRENT_LIMITS: r_cfg.ocw_current_limits <= i_cfg_data[31:0];
                REG_VOLTAGE_DELAYS:     r_cfg.voltage_delays     <= i_cfg_data[23:0];
                REG_FAULT_DELAYS:       r_cfg.fault_delays       <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.converter_enabled    <= i_converter_enabled;
            r_item.ovp_pin_high         <= i_ovp_pin_high;
            r_item.output_voltage       <= i_output_voltage;
            r_item.output_current       <= i_output_current;
            r_item.current_limit_active <= i_current_limit_active;
            r_item.high_line_input      <= i_high_line_input;
            r_item.ct_overcurrent       <= i_ct_overcurrent;
            r_item.clear_ov_latch       <= i_clear_ov_latch;
            r_item.clear_uv_latch       <= i_clear_uv_latch;
            r_item.clear_oc_latch       <= i_clear_oc_latch;
        end
    end

    ofm_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (r_item),
        .o_state (n_state)
    );

    // Monitor state: counters and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_flags <= n_state.flags;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ovp_flag  = r_out_flags[FLAG_OVP];
    assign o_ovw_flag  = r_out_flags[FLAG_OVW];
    assign o_uvp_flag  = r_out_flags[FLAG_UVP];
    assign o_uvw_flag  = r_out_flags[FLAG_UVW];
    assign o_ocp_flag  = r_out_flags[FLAG_OCP];
    assign o_ocw_flag  = r_out_flags[FLAG_OCW];

    // A disabled tick leaves every debounce counter at zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_item.converter_enabled) |=>
            (r_state.pin_count == '0 && r_state.ovp_count == '0 &&
             r_state.ovw_count == '0 && r_state.uvp_count == '0 &&
             r_state.ocp_count == '0 && r_state.ocw_count == '0))
        else $error("counters not cleared by a disabled tick");

    // Flags change only when a tick is evaluated.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state.flags))
        else $error("flags changed without a tick");

    // The delivered flags always match the monitor state they came from.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_valid && r_out_flags == r_state.flags))
        else $error("output flags differ from monitor state");

    // The input side stalls only while a tick waits for the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked tick");

endmodule

`default_nettype wire
